@@ rtl/tmdr_pkg.sv @@
// Shared types and constants for the tile map with dirty rectangle.
// Used by every module in rtl/ but tmdr_ram; depends on nothing.
`default_nettype none

package tmdr_pkg;

  localparam int MAX_DIM_DEF   = 256;
  localparam int TILE_BITS_DEF = 16;

  localparam int DIM_W    = 9;   // map_width / map_height register width
  localparam int COORD_W  = 16;
  localparam int RADIUS_W = 15;
  localparam int TILE_W   = 16;
  localparam int POS_W    = 8;   // region_x / region_y
  localparam int SPAN_W   = 9;   // region_w / region_h
  localparam int OP_W     = 3;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 56;

  // configuration register indexes
  localparam logic REG_MAP_WIDTH  = 1'b0;
  localparam logic REG_MAP_HEIGHT = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SET   = 3'd0,
    OP_BRUSH = 3'd1,
    OP_FILL  = 3'd2,
    OP_TAKE  = 3'd3,
    OP_READ  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLIPX,
    ST_CLIPY,
    ST_READ,
    ST_CHECK,
    ST_FILL,
    ST_TAKE,
    ST_MISS
  } state_e;

  // commands to the dirty box; at most one is set in a cycle
  typedef struct packed {
    logic load;   // replace the box, mark dirty
    logic grow;   // merge a rectangle into the box
    logic clear;  // drop the dirty mark
  } box_cmd_t;

endpackage

`default_nettype wire

@@ rtl/tile_map_with_dirty_rectangle.sv @@
// Channel  | Dir | Signals                       | Carries
// s_axis   | in  | tvalid tready tdata tuser     | one map operation
// m_axis   | out | tvalid tready tdata tuser     | result of take or read
// cfg      | in  | valid ready index data        | map_width / map_height
//
// Set, brush and read use the single clip unit once per axis, then make one RAM read and
// at most one write per clipped cell; a set or read outside the map stops after the clip,
// a read there answering with a miss. Fill writes every cell of the store and marks the
// whole map dirty; take returns the dirty box and clears its mark.
// A finished result waits in the output register while the next operation is taken; an
// operation whose own result finds that register still full holds until it drains.
// Reset clears control and the dirty box and sets map_width and map_height to 256; the tile store has no clearing pass.
// Config is always ready.
// Depends on tmdr_pkg, tmdr_ram, tmdr_clip and tmdr_box.
`default_nettype none

module tile_map_with_dirty_rectangle
  import tmdr_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int TILE_BITS = TILE_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // x [15:0], y [31:16], radius [46:32], tile_id [62:47], zero [63]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // op [2:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tile_value [15:0], region_x [23:16], region_y [31:24],
  // region_w [40:32], region_h [49:41], zero [55:50]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // ok [0]
  output logic                        m_axis_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic                   cfg_index,
  input  wire logic [DIM_W-1:0]       cfg_data
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int BW    = (CW + 1 > SPAN_W) ? CW + 1 : SPAN_W;

  // configuration
  logic [DIM_W-1:0] width_q, height_q, w_eff, h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MAP_WIDTH:  width_q  <= cfg_data;
        REG_MAP_HEIGHT: height_q <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = (width_q == '0) ? DIM_W'(1)
          : ((32'(width_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : width_q);
    h_eff = (height_q == '0) ? DIM_W'(1)
          : ((32'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_q);
  end

  // operation registers
  state_e                      state_q, state_d;
  op_e                         op_q;
  logic signed [COORD_W-1:0]   x_q, y_q;
  logic        [RADIUS_W-1:0]  rad_q;
  logic        [TILE_BITS-1:0] id_q;
  logic        [CW-1:0]        x0_q, x1_q, y0_q, y1_q, cx_q, cy_q;
  logic                        empty_x_q, changed_q;
  logic        [AW-1:0]        fill_cnt_q;

  // input fields
  op_e                       in_op;
  logic        [RADIUS_W-1:0] in_radius;
  logic                      in_xfer;

  assign in_op     = op_e'(s_axis_tuser);
  assign in_radius = s_axis_tdata[46:32];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer   = s_axis_tvalid && s_axis_tready;

  // shared clip unit
  logic signed [COORD_W-1:0] clip_c;
  logic        [DIM_W-1:0]   clip_lim;
  logic        [CW-1:0]      clip_lo, clip_hi;
  logic                      clip_empty;

  tmdr_clip #(.CW(CW)) u_clip (
    .coord_i (clip_c),
    .rad_i   (rad_q),
    .lim_i   (clip_lim),
    .lo_o    (clip_lo),
    .hi_o    (clip_hi),
    .empty_o (clip_empty)
  );

  // tile store
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, cell_addr;
  logic [TILE_BITS-1:0] ram_rdata;

  assign cell_addr = {cy_q, cx_q};

  tmdr_ram #(.WIDTH(TILE_BITS), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (id_q),
    .re_i    (ram_re),
    .raddr_i (cell_addr),
    .rdata_o (ram_rdata)
  );

  // dirty box
  box_cmd_t      box_cmd;
  logic [CW-1:0] box_l, box_t, box_r, box_b;
  logic          box_flag;
  logic [CW-1:0] box_left, box_top, box_right, box_bottom;

  tmdr_box #(.CW(CW)) u_box (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (box_cmd),
    .left_i   (box_l),
    .top_i    (box_t),
    .right_i  (box_r),
    .bottom_i (box_b),
    .flag_o   (box_flag),
    .left_o   (box_left),
    .top_o    (box_top),
    .right_o  (box_right),
    .bottom_o (box_bottom)
  );

  // cell walk flags
  logic cell_diff, row_end, walk_last, emit_ok;

  assign cell_diff = ram_rdata != id_q;
  assign row_end   = cx_q == x1_q;
  assign walk_last = row_end && (cy_q == y1_q);
  assign emit_ok   = !m_axis_tvalid || m_axis_tready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_op)
            OP_SET, OP_BRUSH, OP_READ: state_d = ST_CLIPX;
            OP_FILL:                   state_d = ST_FILL;
            OP_TAKE:                   state_d = ST_TAKE;
            default:                   state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLIPX: state_d = ST_CLIPY;
      ST_CLIPY: begin
        if (empty_x_q || clip_empty) begin
          state_d = (op_q == OP_READ) ? ST_MISS : ST_IDLE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        if (op_q == OP_READ) begin
          if (emit_ok) state_d = ST_IDLE;
        end else begin
          state_d = walk_last ? ST_IDLE : ST_READ;
        end
      end
      ST_FILL: begin
        if (&fill_cnt_q) state_d = ST_IDLE;
      end
      ST_TAKE, ST_MISS: begin
        if (emit_ok) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state outputs
  logic                 emit, res_ok;
  logic [TILE_W-1:0]    res_tile;
  logic [POS_W-1:0]     res_rx, res_ry;
  logic [SPAN_W-1:0]    res_rw, res_rh;
  logic [BW-1:0]        span_w, span_h;

  assign span_w = BW'(box_right) - BW'(box_left) + BW'(1);
  assign span_h = BW'(box_bottom) - BW'(box_top) + BW'(1);

  always_comb begin
    clip_c    = x_q;
    clip_lim  = w_eff;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cell_addr;
    box_cmd   = '0;
    box_l     = x0_q;
    box_t     = y0_q;
    box_r     = x1_q;
    box_b     = y1_q;
    emit      = 1'b0;
    res_ok    = 1'b0;
    res_tile  = '0;
    res_rx    = '0;
    res_ry    = '0;
    res_rw    = '0;
    res_rh    = '0;
    unique case (state_q)
      ST_CLIPY: begin
        clip_c   = y_q;
        clip_lim = h_eff;
      end
      ST_READ: ram_re = 1'b1;
      ST_CHECK: begin
        if (op_q == OP_READ) begin
          emit     = emit_ok;
          res_ok   = 1'b1;
          res_tile = TILE_W'(ram_rdata);
        end else begin
          ram_we       = cell_diff;
          box_cmd.grow = walk_last && (changed_q || cell_diff);
        end
      end
      ST_FILL: begin
        ram_we       = 1'b1;
        ram_waddr    = fill_cnt_q;
        box_cmd.load = &fill_cnt_q;
        box_l        = '0;
        box_t        = '0;
        box_r        = CW'(w_eff - DIM_W'(1));
        box_b        = CW'(h_eff - DIM_W'(1));
      end
      ST_TAKE: begin
        emit          = emit_ok;
        box_cmd.clear = emit_ok;
        if (box_flag) begin
          res_ok = 1'b1;
          res_rx = POS_W'(box_left);
          res_ry = POS_W'(box_top);
          res_rw = SPAN_W'(span_w);
          res_rh = SPAN_W'(span_h);
        end
      end
      ST_MISS: emit = emit_ok;
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      op_q       <= in_op;
      x_q        <= $signed(s_axis_tdata[15:0]);
      y_q        <= $signed(s_axis_tdata[31:16]);
      id_q       <= s_axis_tdata[47 +: TILE_BITS];
      fill_cnt_q <= '0;
      // set and read act as a single-cell brush
      if (in_op == OP_BRUSH && in_radius != '0) begin
        rad_q <= in_radius - RADIUS_W'(1);
      end else begin
        rad_q <= '0;
      end
    end
    unique case (state_q)
      ST_CLIPX: begin
        x0_q      <= clip_lo;
        x1_q      <= clip_hi;
        empty_x_q <= clip_empty;
      end
      ST_CLIPY: begin
        y0_q      <= clip_lo;
        y1_q      <= clip_hi;
        cx_q      <= x0_q;
        cy_q      <= clip_lo;
        changed_q <= 1'b0;
      end
      ST_CHECK: begin
        if (cell_diff) changed_q <= 1'b1;
        // advance along the row, then wrap to the next row
        if (row_end) begin
          cx_q <= x0_q;
          cy_q <= cy_q + CW'(1);
        end else begin
          cx_q <= cx_q + CW'(1);
        end
      end
      ST_FILL: fill_cnt_q <= fill_cnt_q + AW'(1);
      default: ;
    endcase
    if (emit) begin
      m_axis_tuser <= res_ok;
      m_axis_tdata <= {6'b0, res_rh, res_rw, res_ry, res_rx, res_tile};
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmdr_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies; contents are undefined until written.
`default_nettype none

module tmdr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // hold the last read word while re_i is low
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

@@ rtl/tmdr_clip.sv @@
// Shared clip unit: turns a centre and half-width into a range clipped to
// [0, lim-1] on one axis. Depends on tmdr_pkg.
`default_nettype none

module tmdr_clip
  import tmdr_pkg::*;
#(
  parameter int CW = 8
) (
  input  wire logic signed [COORD_W-1:0]  coord_i,
  input  wire logic        [RADIUS_W-1:0] rad_i,
  input  wire logic        [DIM_W-1:0]    lim_i,
  output logic             [CW-1:0]       lo_o,
  output logic             [CW-1:0]       hi_o,
  output logic                            empty_o
);

  logic signed [17:0] c_s;
  logic signed [17:0] r_s;
  logic signed [17:0] last_s;
  logic signed [17:0] lo_raw;
  logic signed [17:0] hi_raw;
  logic signed [17:0] lo_s;
  logic signed [17:0] hi_s;

  always_comb begin
    c_s    = 18'(coord_i);
    r_s    = $signed({3'b000, rad_i});
    last_s = $signed({9'b0, lim_i}) - 18'sd1;
    lo_raw = c_s - r_s;
    hi_raw = c_s + r_s;
    lo_s   = (lo_raw < 18'sd0) ? 18'sd0 : lo_raw;
    hi_s   = (hi_raw > last_s) ? last_s : hi_raw;
    // a non-empty range lies inside the map, so the low bits carry it whole
    empty_o = lo_s > hi_s;
    lo_o    = lo_s[CW-1:0];
    hi_o    = hi_s[CW-1:0];
  end

endmodule

`default_nettype wire

@@ rtl/tmdr_box.sv @@
// Dirty bounding box: load, grow by a rectangle, clear on take.
// Depends on tmdr_pkg for the command struct.
`default_nettype none

module tmdr_box
  import tmdr_pkg::*;
#(
  parameter int CW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire box_cmd_t      cmd_i,
  input  wire logic [CW-1:0] left_i,
  input  wire logic [CW-1:0] top_i,
  input  wire logic [CW-1:0] right_i,
  input  wire logic [CW-1:0] bottom_i,
  output logic               flag_o,
  output logic      [CW-1:0] left_o,
  output logic      [CW-1:0] top_o,
  output logic      [CW-1:0] right_o,
  output logic      [CW-1:0] bottom_o
);

  logic          flag_q, flag_d;
  logic [CW-1:0] left_q, left_d, top_q, top_d, right_q, right_d, bottom_q, bottom_d;

  always_comb begin
    flag_d   = flag_q;
    left_d   = left_q;
    top_d    = top_q;
    right_d  = right_q;
    bottom_d = bottom_q;
    if (cmd_i.load || (cmd_i.grow && !flag_q)) begin
      flag_d   = 1'b1;
      left_d   = left_i;
      top_d    = top_i;
      right_d  = right_i;
      bottom_d = bottom_i;
    end else if (cmd_i.grow) begin
      if (left_i < left_q)     left_d   = left_i;
      if (top_i < top_q)       top_d    = top_i;
      if (right_i > right_q)   right_d  = right_i;
      if (bottom_i > bottom_q) bottom_d = bottom_i;
    end else if (cmd_i.clear) begin
      flag_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q   <= 1'b0;
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
    end else begin
      flag_q   <= flag_d;
      left_q   <= left_d;
      top_q    <= top_d;
      right_q  <= right_d;
      bottom_q <= bottom_d;
    end
  end

  assign flag_o   = flag_q;
  assign left_o   = left_q;
  assign top_o    = top_q;
  assign right_o  = right_q;
  assign bottom_o = bottom_q;

  a_box_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flag_q |-> (left_q <= right_q) && (top_q <= bottom_q))
    else $error("dirty box has inverted edges");

  a_clear_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear && !cmd_i.load && !cmd_i.grow |=> !flag_q)
    else $error("dirty mark survived a take");

  a_load_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && left_i == '0 && top_i == '0 |=> flag_q && left_q == '0 && top_q == '0)
    else $error("fill did not mark the map from the origin");

  a_grow_shrinks_not: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grow && flag_q |=> left_q <= $past(left_q) && right_q >= $past(right_q))
    else $error("growing the box shrank it");

endmodule

`default_nettype wire
